// ===== src/cpu8_arith_flags_unit_assert.svh =====
// ----------------------------------------------------------------------------
// cpu8_arith_flags_unit_assert.svh
// Assertion macros shared by the checker of the arithmetic/flags unit.
// ----------------------------------------------------------------------------
`ifndef CPU8_ARITH_FLAGS_UNIT_ASSERT_SVH
`define CPU8_ARITH_FLAGS_UNIT_ASSERT_SVH

// Check a property outside reset only.
`define CPU8AF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cpu8af checker: property violated");

// Check a property at every edge, reset included.
`define CPU8AF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("cpu8af checker: property violated");

`endif

// ===== src/cpu8af_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8af_pkg
// Types, codes and sizes shared by the 8-bit arithmetic and flags unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpu8af_pkg;

  // Opcodes of the input word
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_ADI = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_SUI = 4'd3;
  localparam logic [3:0] OP_INR = 4'd4;
  localparam logic [3:0] OP_DCR = 4'd5;
  localparam logic [3:0] OP_INX = 4'd6;
  localparam logic [3:0] OP_DCX = 4'd7;
  localparam logic [3:0] OP_DAD = 4'd8;

  // Register indexes
  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;

  // Register pair indexes
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;

  // Queue depths
  localparam int unsigned IQ_DEPTH = 2;
  localparam int unsigned RQ_DEPTH = 2;

  typedef enum logic [2:0] {
    EX_ADD,
    EX_SUB,
    EX_INR,
    EX_DCR,
    EX_INX,
    EX_DCX,
    EX_DAD,
    EX_BAD
  } exec_kind_e;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] reg_sel;
    logic [7:0] immediate;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  accumulator;
    logic [15:0] written_value;
    logic        sign_flag;
    logic        zero_flag;
    logic        aux_carry_flag;
    logic        parity_flag;
    logic        carry_flag;
    logic        bad_select;
  } out_word_t;

  // Decoded instruction handed from front to back
  typedef struct packed {
    exec_kind_e kind;
    logic       use_imm;
    logic [2:0] reg_idx;
    logic [1:0] pair_idx;
    logic [7:0] imm;
  } dec_word_t;

  // Flags: S, Z, AC, P, CY
  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  // Head of the instruction queue as seen by the back end
  typedef struct packed {
    logic      valid;
    dec_word_t word;
  } iq_head_t;

endpackage

// ===== src/cpu8_arith_flags_unit.sv =====
// A word accepted into the instruction queue executes from its head and its result is registered in the result queue.
// Throughput: one word per cycle while the result queue has room, set by the execute stage on the register file.
// A full result queue stalls execution; the instruction queue keeps taking words until full.
// Reset (rst_ni low, asynchronous) clears registers A..L, all flags and both queues.
// ----------------------------------------------------------------------------
// cpu8_arith_flags_unit
// 8-bit arithmetic unit with kept register file and flags, queue interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu8_arith_flags_unit
  import cpu8af_pkg::*;
#(
  parameter int unsigned IqDepth = IQ_DEPTH,
  parameter int unsigned RqDepth = RQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  logic      iq_full;
  logic      iq_push;
  dec_word_t iq_word;
  logic      iq_pop;
  iq_head_t  iq_head;

  // Decode incoming words
  cpu8af_front u_front (
    .push_i    (push),
    .in_word_i (in_word_i),
    .iq_full_i (iq_full),
    .full_o    (full),
    .iq_push_o (iq_push),
    .iq_word_o (iq_word)
  );

  // Buffer decoded instructions
  cpu8af_iq #(
    .Depth (IqDepth)
  ) u_iq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (iq_push),
    .word_i (iq_word),
    .full_o (iq_full),
    .pop_i  (iq_pop),
    .head_o (iq_head)
  );

  // Execute and queue results
  cpu8af_back #(
    .RqDepth (RqDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (iq_head),
    .iq_pop_o   (iq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

endmodule

// ===== src/cpu8af_front.sv =====
// ----------------------------------------------------------------------------
// cpu8af_front
// Accepts input words and classifies them into decoded instructions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu8af_front
  import cpu8af_pkg::*;
(
  input  logic      push_i,
  input  in_word_t  in_word_i,
  input  logic      iq_full_i,
  output logic      full_o,
  output logic      iq_push_o,
  output dec_word_t iq_word_o
);

  // Accept whenever the instruction queue has room
  assign full_o    = iq_full_i;
  assign iq_push_o = push_i && !iq_full_i;

  // Classify opcode and check the selector
  always_comb begin
    iq_word_o.use_imm  = 1'b0;
    iq_word_o.reg_idx  = in_word_i.reg_sel;
    iq_word_o.pair_idx = in_word_i.reg_sel[1:0];
    iq_word_o.imm      = in_word_i.immediate;
    iq_word_o.kind     = EX_BAD;
    unique case (in_word_i.op)
      OP_ADD: begin
        iq_word_o.kind = (in_word_i.reg_sel > REG_L) ? EX_BAD : EX_ADD;
      end
      OP_ADI: begin
        iq_word_o.kind    = EX_ADD;
        iq_word_o.use_imm = 1'b1;
      end
      OP_SUB: begin
        iq_word_o.kind = (in_word_i.reg_sel > REG_L) ? EX_BAD : EX_SUB;
      end
      OP_SUI: begin
        iq_word_o.kind    = EX_SUB;
        iq_word_o.use_imm = 1'b1;
      end
      OP_INR: begin
        iq_word_o.kind = (in_word_i.reg_sel > REG_L) ? EX_BAD : EX_INR;
      end
      OP_DCR: begin
        iq_word_o.kind = (in_word_i.reg_sel > REG_L) ? EX_BAD : EX_DCR;
      end
      OP_INX: begin
        iq_word_o.kind = (in_word_i.reg_sel > {1'b0, PAIR_HL}) ? EX_BAD : EX_INX;
      end
      OP_DCX: begin
        iq_word_o.kind = (in_word_i.reg_sel > {1'b0, PAIR_HL}) ? EX_BAD : EX_DCX;
      end
      OP_DAD: begin
        iq_word_o.kind = (in_word_i.reg_sel > {1'b0, PAIR_HL}) ? EX_BAD : EX_DAD;
      end
      default: begin
        iq_word_o.kind = EX_BAD;
      end
    endcase
  end

endmodule

// ===== src/cpu8af_iq.sv =====
// ----------------------------------------------------------------------------
// cpu8af_iq
// Short queue of decoded instructions between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu8af_iq
  import cpu8af_pkg::*;
#(
  parameter int unsigned Depth = IQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dec_word_t word_i,
  output logic      full_o,
  input  logic      pop_i,
  output iq_head_t  head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dec_word_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.word  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

// ===== src/cpu8af_back.sv =====
// ----------------------------------------------------------------------------
// cpu8af_back
// Executes decoded instructions on the register file and flags, and queues
// the result words for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu8af_back
  import cpu8af_pkg::*;
#(
  parameter int unsigned RqDepth = RQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iq_head_t  head_i,
  output logic      iq_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_word_t out_word_o
);

  localparam int unsigned PtrW = $clog2(RqDepth);
  localparam int unsigned CntW = $clog2(RqDepth + 1);

  // Register file and flags
  logic [7:0] a_q, b_q, c_q, d_q, e_q, h_q, l_q;
  logic [7:0] a_d, b_d, c_d, d_d, e_d, h_d, l_d;
  flags_t     flags_q, flags_d;

  // Result queue
  out_word_t       rq_mem_q [RqDepth];
  logic [PtrW-1:0] rq_wr_q, rq_wr_d;
  logic [PtrW-1:0] rq_rd_q, rq_rd_d;
  logic [CntW-1:0] rq_cnt_q, rq_cnt_d;
  logic            rq_pop;

  dec_word_t  dw;
  logic       exec_fire;
  logic [7:0] reg_val;
  logic [15:0] pair_val;
  logic [15:0] hl_val;
  logic       is_sub;
  logic [7:0] op_a, op_b, op_b_eff;
  logic [8:0] sum9;
  logic [4:0] nib5;
  logic [7:0] res8;
  flags_t     flags8;
  logic [15:0] base16, addend16;
  logic [16:0] sum17;
  out_word_t  res_word;

  assign dw        = head_i.word;
  assign exec_fire = head_i.valid && (rq_cnt_q != CntW'(RqDepth));
  assign iq_pop_o  = exec_fire;

  // Read operands
  always_comb begin
    unique case (dw.reg_idx)
      REG_A:   reg_val = a_q;
      REG_B:   reg_val = b_q;
      REG_C:   reg_val = c_q;
      REG_D:   reg_val = d_q;
      REG_E:   reg_val = e_q;
      REG_H:   reg_val = h_q;
      REG_L:   reg_val = l_q;
      default: reg_val = a_q;
    endcase
    unique case (dw.pair_idx)
      PAIR_BC: pair_val = {b_q, c_q};
      PAIR_DE: pair_val = {d_q, e_q};
      default: pair_val = {h_q, l_q};
    endcase
  end
  assign hl_val = {h_q, l_q};

  // 8-bit adder: subtract as a + ~b + 1, carry inverted to borrow
  assign is_sub   = (dw.kind == EX_SUB) || (dw.kind == EX_DCR);
  assign op_a     = ((dw.kind == EX_INR) || (dw.kind == EX_DCR)) ? reg_val : a_q;
  assign op_b     = ((dw.kind == EX_INR) || (dw.kind == EX_DCR)) ? 8'd1 :
                    (dw.use_imm ? dw.imm : reg_val);
  assign op_b_eff = is_sub ? ~op_b : op_b;
  assign sum9     = {1'b0, op_a} + {1'b0, op_b_eff} + {8'd0, is_sub};
  assign nib5     = {1'b0, op_a[3:0]} + {1'b0, op_b_eff[3:0]} + {4'd0, is_sub};
  assign res8     = sum9[7:0];

  always_comb begin
    flags8.s  = res8[7];
    flags8.z  = (res8 == 8'd0);
    flags8.ac = nib5[4];
    flags8.p  = ~(^res8);
    flags8.cy = sum9[8] ^ is_sub;
  end

  // 16-bit adder shared by INX, DCX and DAD
  assign base16   = (dw.kind == EX_DAD) ? hl_val : pair_val;
  assign addend16 = (dw.kind == EX_DAD) ? pair_val :
                    (dw.kind == EX_DCX) ? 16'hFFFF : 16'd1;
  assign sum17    = {1'b0, base16} + {1'b0, addend16};

  // Next register, flag and result values
  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    h_d     = h_q;
    l_d     = l_q;
    flags_d = flags_q;
    res_word.written_value = 16'd0;
    res_word.bad_select    = 1'b0;
    unique case (dw.kind)
      EX_ADD, EX_SUB: begin
        a_d     = res8;
        flags_d = flags8;
        res_word.written_value = {8'd0, res8};
      end
      EX_INR, EX_DCR: begin
        unique case (dw.reg_idx)
          REG_A:   a_d = res8;
          REG_B:   b_d = res8;
          REG_C:   c_d = res8;
          REG_D:   d_d = res8;
          REG_E:   e_d = res8;
          REG_H:   h_d = res8;
          REG_L:   l_d = res8;
          default: a_d = a_q;
        endcase
        flags_d    = flags8;
        flags_d.cy = flags_q.cy;
        res_word.written_value = {8'd0, res8};
      end
      EX_INX, EX_DCX: begin
        unique case (dw.pair_idx)
          PAIR_BC: {b_d, c_d} = sum17[15:0];
          PAIR_DE: {d_d, e_d} = sum17[15:0];
          default: {h_d, l_d} = sum17[15:0];
        endcase
        res_word.written_value = sum17[15:0];
      end
      EX_DAD: begin
        {h_d, l_d} = sum17[15:0];
        flags_d.cy = sum17[16];
        res_word.written_value = sum17[15:0];
      end
      default: begin
        res_word.bad_select = 1'b1;
      end
    endcase
    res_word.accumulator    = a_d;
    res_word.sign_flag      = flags_d.s;
    res_word.zero_flag      = flags_d.z;
    res_word.aux_carry_flag = flags_d.ac;
    res_word.parity_flag    = flags_d.p;
    res_word.carry_flag     = flags_d.cy;
  end

  // Commit architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      e_q     <= '0;
      h_q     <= '0;
      l_q     <= '0;
      flags_q <= '0;
    end else if (exec_fire) begin
      a_q     <= a_d;
      b_q     <= b_d;
      c_q     <= c_d;
      d_q     <= d_d;
      e_q     <= e_d;
      h_q     <= h_d;
      l_q     <= l_d;
      flags_q <= flags_d;
    end
  end

  // Result queue control
  assign empty_o    = (rq_cnt_q == '0);
  assign rq_pop     = pop_i && !empty_o;
  assign out_word_o = rq_mem_q[rq_rd_q];

  always_comb begin
    rq_wr_d  = rq_wr_q;
    rq_rd_d  = rq_rd_q;
    rq_cnt_d = rq_cnt_q;
    if (exec_fire) begin
      rq_wr_d = (rq_wr_q == PtrW'(RqDepth - 1)) ? '0 : rq_wr_q + 1'b1;
    end
    if (rq_pop) begin
      rq_rd_d = (rq_rd_q == PtrW'(RqDepth - 1)) ? '0 : rq_rd_q + 1'b1;
    end
    if (exec_fire && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + 1'b1;
    end else if (rq_pop && !exec_fire) begin
      rq_cnt_d = rq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_wr_q  <= rq_wr_d;
      rq_rd_q  <= rq_rd_d;
      rq_cnt_q <= rq_cnt_d;
    end
  end

  // Hold result words until popped
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      rq_mem_q[rq_wr_q] <= res_word;
    end
  end

endmodule

// ===== src/cpu8af_checker.sv =====
// ----------------------------------------------------------------------------
// cpu8af_checker
// Port-level checks on the arithmetic/flags unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu8_arith_flags_unit_assert.svh"

module cpu8af_checker
  import cpu8af_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word_o
);

  // Both queues come out of reset drained
  `CPU8AF_ASSERT_ALWAYS(a_reset_drained, clk_i, !rst_ni |=> (empty && !full))

  // A word into an idle unit passes through the instruction queue and the result queue to the result side
  `CPU8AF_ASSERT(a_idle_latency, clk_i, rst_ni, (empty && push && !full) |-> ##2 !empty)

  // A rejected selector reports no written value
  `CPU8AF_ASSERT(a_bad_no_write, clk_i, rst_ni, (!empty && out_word_o.bad_select) |-> (out_word_o.written_value == 16'd0))

  // A waiting result stays until popped
  `CPU8AF_ASSERT(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_word_o)))

endmodule

bind cpu8_arith_flags_unit cpu8af_checker u_checker (.*);

// ===== tb/cpu8_arith_flags_unit_test.sv =====
// ----------------------------------------------------------------------------
// cpu8_arith_flags_unit_test
// Self-checking bench for the 8-bit arithmetic and flags unit. Instruction
// words go in through the input queue. A predictor keeps its own register
// file and flags and computes each expected result word. Every popped word is
// compared field by field against the oldest prediction. Directed words cover
// flag corner cases and invalid selects. Random words then run with random
// gaps on both sides, a long result stall, and back-to-back bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu8_arith_flags_unit_test;
  import cpu8af_pkg::*;

  // Codes outside the legal op and register ranges
  localparam logic [3:0] OP_UNUSED_MIN = OP_DAD + 4'd1;
  localparam logic [3:0] OP_UNUSED_MAX = 4'hF;
  localparam logic [2:0] REG_NONE      = 3'd7;
  localparam logic [2:0] PAIR_NONE     = 3'(PAIR_HL) + 3'd1;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      push     = 1'b0;
  logic      pop      = 1'b0;
  logic      full;
  logic      empty;
  in_word_t  in_word  = '0;
  out_word_t out_word;

  // Predictor state
  logic [7:0] model_regs [7];
  flags_t     model_flags;

  out_word_t  expected_q [$];
  out_word_t  want_word;

  int unsigned error_count     = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned bad_results     = 0;
  int unsigned result_hold     = 0;
  int unsigned stall_left      = 0;
  bit          send_quiet      = 1'b0;
  bit          recv_quiet      = 1'b0;

  cpu8_arith_flags_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // 8-bit add or subtract with all five flags; subtract is a + ~b + 1
  function automatic logic [7:0] alu8(input logic [7:0] a, input logic [7:0] b,
                                      input logic is_sub, output flags_t f);
    logic [7:0] bx;
    logic [8:0] sum;
    logic [4:0] low;
    bx   = is_sub ? ~b : b;
    sum  = {1'b0, a} + {1'b0, bx} + 9'(is_sub);
    low  = {1'b0, a[3:0]} + {1'b0, bx[3:0]} + 5'(is_sub);
    f.s  = sum[7];
    f.z  = (sum[7:0] == 8'h00);
    f.ac = low[4];
    f.p  = ~^sum[7:0];
    f.cy = sum[8] ^ is_sub;
    return sum[7:0];
  endfunction

  // Execute one instruction on the predictor state and build its result word
  function automatic out_word_t execute_instr(input in_word_t w);
    out_word_t  o;
    flags_t     f;
    flags_t     nf;
    logic [7:0] r;
    logic [15:0] pv;
    logic [15:0] wv;
    logic [16:0] wide;
    logic       bad;
    int         hi;
    f   = model_flags;
    bad = 1'b0;
    wv  = '0;
    hi  = int'(REG_B) + 2 * int'(w.reg_sel);
    case (w.op)
      OP_ADD, OP_SUB: begin
        if (w.reg_sel > REG_L) begin
          bad = 1'b1;
        end else begin
          r = alu8(model_regs[REG_A], model_regs[w.reg_sel], w.op == OP_SUB, nf);
          model_regs[REG_A] = r;
          f  = nf;
          wv = 16'(r);
        end
      end
      OP_ADI, OP_SUI: begin
        r = alu8(model_regs[REG_A], w.immediate, w.op == OP_SUI, nf);
        model_regs[REG_A] = r;
        f  = nf;
        wv = 16'(r);
      end
      OP_INR, OP_DCR: begin
        if (w.reg_sel > REG_L) begin
          bad = 1'b1;
        end else begin
          r = alu8(model_regs[w.reg_sel], 8'd1, w.op == OP_DCR, nf);
          model_regs[w.reg_sel] = r;
          nf.cy = f.cy;
          f  = nf;
          wv = 16'(r);
        end
      end
      OP_INX, OP_DCX: begin
        if (w.reg_sel > 3'(PAIR_HL)) begin
          bad = 1'b1;
        end else begin
          pv = {model_regs[hi], model_regs[hi + 1]};
          pv = (w.op == OP_INX) ? pv + 16'd1 : pv - 16'd1;
          {model_regs[hi], model_regs[hi + 1]} = pv;
          wv = pv;
        end
      end
      OP_DAD: begin
        if (w.reg_sel > 3'(PAIR_HL)) begin
          bad = 1'b1;
        end else begin
          wide = {1'b0, model_regs[REG_H], model_regs[REG_L]}
               + {1'b0, model_regs[hi], model_regs[hi + 1]};
          f.cy = wide[16];
          {model_regs[REG_H], model_regs[REG_L]} = wide[15:0];
          wv = wide[15:0];
        end
      end
      default: bad = 1'b1;
    endcase
    model_flags      = f;
    o.accumulator    = model_regs[REG_A];
    o.written_value  = bad ? 16'h0000 : wv;
    o.sign_flag      = f.s;
    o.zero_flag      = f.z;
    o.aux_carry_flag = f.ac;
    o.parity_flag    = f.p;
    o.carry_flag     = f.cy;
    o.bad_select     = bad;
    return o;
  endfunction

  function automatic in_word_t word_of(input logic [3:0] op, input logic [2:0] sel,
                                       input logic [7:0] imm);
    in_word_t w;
    w.op        = op;
    w.reg_sel   = sel;
    w.immediate = imm;
    return w;
  endfunction

  // Mostly legal instructions, a few invalid ops and selectors
  function automatic in_word_t random_instr();
    in_word_t w;
    logic [7:0] edges [7];
    edges = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 99) < 5) w.op = 4'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
    else w.op = 4'($urandom_range(OP_ADD, OP_DAD));
    case (w.op)
      OP_INX, OP_DCX, OP_DAD: begin
        if ($urandom_range(0, 99) < 90) w.reg_sel = 3'($urandom_range(PAIR_BC, PAIR_HL));
        else w.reg_sel = 3'($urandom_range(PAIR_NONE, REG_NONE));
      end
      default: begin
        if ($urandom_range(0, 99) < 93) w.reg_sel = 3'($urandom_range(REG_A, REG_L));
        else w.reg_sel = REG_NONE;
      end
    endcase
    if ($urandom_range(0, 99) < 80) w.immediate = 8'($urandom_range(0, 255));
    else w.immediate = edges[$urandom_range(0, 6)];
    return w;
  endfunction

  // Offer one word after an optional gap; predict it once accepted.
  // Entered and left at a falling edge.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    expected_q.insert(expected_q.size(), execute_instr(w));
    words_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and hold until every predicted word has been popped
  task automatic wait_for_results();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_word(random_instr());
  endtask

  // Flag corners, register pair wrap, and invalid selects from reset state
  task automatic test_directed();
    send_word(word_of(OP_SUB, REG_A, 8'h00));        // SUB A gives 0 with AC set
    send_word(word_of(OP_ADI, REG_A, 8'hFF));
    send_word(word_of(OP_ADI, REG_A, 8'h01));        // wrap to zero with carry
    send_word(word_of(OP_SUI, REG_A, 8'h00));        // subtract of zero
    send_word(word_of(OP_SUI, REG_A, 8'hFF));        // borrow
    send_word(word_of(OP_INR, REG_B, 8'h00));
    send_word(word_of(OP_DCR, REG_C, 8'h00));        // 00 -> FF, carry kept
    send_word(word_of(OP_ADD, REG_C, 8'h00));
    send_word(word_of(OP_SUB, REG_B, 8'h00));
    send_word(word_of(OP_DCX, 3'(PAIR_DE), 8'h00));  // 0000 -> FFFF
    send_word(word_of(OP_INX, 3'(PAIR_BC), 8'h00));
    send_word(word_of(OP_DAD, 3'(PAIR_DE), 8'h00));
    send_word(word_of(OP_DAD, 3'(PAIR_HL), 8'h00));  // 16-bit carry out
    send_word(word_of(OP_INX, 3'(PAIR_HL), 8'h00));
    send_word(word_of(OP_DAD, 3'(PAIR_BC), 8'h00));
    send_word(word_of(OP_ADD, REG_L, 8'h00));
    send_word(word_of(OP_SUB, REG_A, 8'h00));        // SUB A with nonzero A
    send_word(word_of(OP_UNUSED_MIN, REG_A, 8'hFF));
    send_word(word_of(OP_UNUSED_MAX, REG_NONE, 8'hFF));
    send_word(word_of(OP_ADD, REG_NONE, 8'h00));
    send_word(word_of(OP_INR, REG_NONE, 8'h00));
    send_word(word_of(OP_DCR, REG_NONE, 8'h00));
    send_word(word_of(OP_INX, PAIR_NONE, 8'h00));
    send_word(word_of(OP_DCX, REG_NONE, 8'h00));
    send_word(word_of(OP_DAD, PAIR_NONE, 8'h00));
    wait_for_results();
  endtask

  // Stall the result side for a long stretch while words keep coming
  task automatic test_result_backpressure();
    send_quiet  = 1'b1;
    result_hold = HOLD_CYCLES;
    send_random(20);
    send_quiet  = 1'b0;
    wait_for_results();
  endtask

  // Back-to-back words with pop held high
  task automatic test_back_to_back();
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    send_random(200);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    wait_for_results();
  endtask

  // Random words with random gaps on both sides
  task automatic test_random_traffic();
    send_random(1100);
    wait_for_results();
  endtask

  // Result side: random stalls, or a long hold when one is requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (result_hold > 0) begin
        pop <= 1'b0;
        repeat (result_hold - 1) @(negedge clk_i);
        result_hold = 0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = recv_quiet ? 0 : pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare each popped word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result word popped with no prediction pending");
        error_count++;
      end else begin
        want_word = expected_q.pop_front();
        results_checked++;
        if (want_word.bad_select) bad_results++;
        check_field("accumulator", 16'(want_word.accumulator), 16'(out_word.accumulator));
        check_field("written_value", want_word.written_value, out_word.written_value);
        check_field("sign_flag", 16'(want_word.sign_flag), 16'(out_word.sign_flag));
        check_field("zero_flag", 16'(want_word.zero_flag), 16'(out_word.zero_flag));
        check_field("aux_carry_flag", 16'(want_word.aux_carry_flag),
                    16'(out_word.aux_carry_flag));
        check_field("parity_flag", 16'(want_word.parity_flag), 16'(out_word.parity_flag));
        check_field("carry_flag", 16'(want_word.carry_flag), 16'(out_word.carry_flag));
        check_field("bad_select", 16'(want_word.bad_select), 16'(out_word.bad_select));
      end
    end
  end

  // Sequence: reset, tests, drain, verdict
  initial begin
    for (int i = 0; i < 7; i++) model_regs[i] = 8'h00;
    model_flags = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_result_backpressure();
    test_back_to_back();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d predicted words never popped", expected_q.size());
      error_count++;
    end
    $display("Issued %0d instructions, checked %0d result words (%0d invalid selects),",
             words_sent, results_checked, bad_results);
    $display("with random gaps, a long result stall and back-to-back bursts.");
    if (error_count == 0) begin
      $display("cpu8_arith_flags_unit_test: done, clean");
    end else begin
      $display("cpu8_arith_flags_unit_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("cpu8_arith_flags_unit_test: done, errors");
    $finish;
  end

endmodule
